// ===== hdl/sca_pkg.sv =====
// ============================================================================
// sca_pkg
// Types and constants shared by the segment check and acknowledge block.
// ============================================================================
`default_nettype none

package sca_pkg;

    localparam int HDR_BYTES = 5;
    localparam int ACK_BYTES = 7;
    localparam int POS_W     = 9;
    localparam int LEFT_W    = 3;

    localparam int          RELIABLE_IDX = 4;
    localparam logic [7:0]  ACK_BIT      = 8'h80;
    localparam logic [7:0]  ERR_BIT      = 8'h01;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       rx_first;
    } t_rx_item;

    typedef struct packed {
        logic [7:0] ack_byte;
        logic       ack_last;
        logic       checksum_error;
    } t_ack_item;

    typedef struct packed {
        logic [ACK_BYTES-1:0][7:0] bytes;
        logic                      err;
    } t_ack_rec;

endpackage

`default_nettype wire

// ===== hdl/sca_parse.sv =====
// ============================================================================
// sca_parse
// Segment parser: captures the header, folds the running parity and builds
// the acknowledgement record when a reliable segment completes.
// ============================================================================
`default_nettype none

module sca_parse import sca_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire t_rx_item i_item,
    input  wire logic     i_room,
    output logic          o_stall,
    output logic          o_ack_load,
    output t_ack_rec      o_ack
);

    function automatic logic [15:0] fold(input logic [15:0] par, input logic odd,
                                         input logic [7:0] b);
        logic [15:0] res;
        res = odd ? (par ^ {8'h00, b}) : (par ^ {b, 8'h00});
        return res;
    endfunction

    logic [POS_W-1:0]          r_pos, n_pos;
    logic [15:0]               r_par, n_par;
    logic [HDR_BYTES-1:0][7:0] r_hdr, n_hdr;
    logic [7:0]                r_chk_hi, n_chk_hi;

    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] seg_end;
    logic [15:0]      par;
    logic             accept;
    logic             at_final;
    logic             reliable;
    logic             err;
    logic [7:0]       ctl0;
    logic [7:0]       ack_hi;
    logic [7:0]       ack_lo;

    assign seg_end  = POS_W'(HDR_BYTES) + {1'b0, r_hdr[HDR_BYTES-1]};
    assign reliable = r_hdr[0][RELIABLE_IDX];
    assign at_final = (r_pos == seg_end + POS_W'(1));
    assign o_stall  = at_final && reliable && !i_item.rx_first && !i_room;
    assign accept   = i_valid && !o_stall;

    assign pos = i_item.rx_first ? '0 : r_pos;
    assign par = i_item.rx_first ? '0 : r_par;

    assign err    = (par != {r_chk_hi, i_item.rx_byte});
    assign ctl0   = r_hdr[0] | ACK_BIT | (err ? ERR_BIT : 8'h00);
    assign ack_hi = ctl0 ^ r_hdr[2] ^ r_hdr[4];
    assign ack_lo = r_hdr[1] ^ r_hdr[3];

    always_comb begin
        n_pos      = r_pos;
        n_par      = r_par;
        n_hdr      = r_hdr;
        n_chk_hi   = r_chk_hi;
        o_ack_load = 1'b0;
        if (accept) begin
            n_pos = pos;
            n_par = par;
            if (pos < POS_W'(HDR_BYTES)) begin
                n_hdr[pos[2:0]] = i_item.rx_byte;
                n_par           = fold(par, pos[0], i_item.rx_byte);
                n_pos           = pos + POS_W'(1);
            end else if (pos < seg_end) begin
                n_par = fold(par, pos[0], i_item.rx_byte);
                n_pos = pos + POS_W'(1);
            end else if (pos == seg_end) begin
                n_chk_hi = i_item.rx_byte;
                n_pos    = pos + POS_W'(1);
            end else if (pos == seg_end + POS_W'(1)) begin
                n_pos      = pos + POS_W'(1);
                o_ack_load = reliable;
            end
        end
    end

    assign o_ack.bytes = {ack_lo, ack_hi, r_hdr[4], r_hdr[3], r_hdr[2], r_hdr[1], ctl0};
    assign o_ack.err   = err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_par    <= '0;
            r_hdr    <= '0;
            r_chk_hi <= '0;
        end else begin
            r_pos    <= n_pos;
            r_par    <= n_par;
            r_hdr    <= n_hdr;
            r_chk_hi <= n_chk_hi;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/segment_check_and_ack_core.sv =====
// ============================================================================
// segment_check_and_ack_core
// Checks the parity of received segments and returns a seven-byte
// acknowledgement for each reliable one.
// ============================================================================
// One received byte is taken every cycle unless stalled; a segment's
// acknowledgement is loaded into the output shift register at the edge
// that transfers its last checksum byte, is offered from the next cycle and
// leaves one byte per cycle unless stalled. The input stalls only when the
// final byte of a reliable segment is due and the previous acknowledgement
// has not yet gone out. Synchronous reset clears the parse position, the
// parity, the header and empties the output.
`default_nettype none

module segment_check_and_ack_core import sca_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_rx_valid,
    output logic           o_rx_stall,
    input  wire t_rx_item  i_rx_data,
    output logic           o_ack_valid,
    input  wire logic      i_ack_stall,
    output t_ack_item      o_ack_data
);

    t_ack_rec                  ack_rec;
    logic                      ack_load;
    logic                      ack_room;
    logic                      ack_xfer;
    logic [LEFT_W-1:0]         r_left, n_left;
    logic [ACK_BYTES-1:0][7:0] r_bytes, n_bytes;
    logic                      r_err, n_err;

    assign o_ack_valid = (r_left != '0);
    assign ack_xfer    = o_ack_valid && !i_ack_stall;
    assign ack_room    = !o_ack_valid || (ack_xfer && r_left == LEFT_W'(1));

    sca_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_rx_valid),
        .i_item     (i_rx_data),
        .i_room     (ack_room),
        .o_stall    (o_rx_stall),
        .o_ack_load (ack_load),
        .o_ack      (ack_rec)
    );

    always_comb begin
        n_left  = r_left;
        n_bytes = r_bytes;
        n_err   = r_err;
        if (ack_load) begin
            n_left  = LEFT_W'(ACK_BYTES);
            n_bytes = ack_rec.bytes;
            n_err   = ack_rec.err;
        end else if (ack_xfer) begin
            n_left  = r_left - LEFT_W'(1);
            n_bytes = {8'h00, r_bytes[ACK_BYTES-1:1]};
        end
    end

    assign o_ack_data.ack_byte       = r_bytes[0];
    assign o_ack_data.ack_last       = (r_left == LEFT_W'(1));
    assign o_ack_data.checksum_error = r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else begin
            r_left <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
        r_err   <= n_err;
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ack_load |-> (!o_ack_valid || (o_ack_data.ack_last && !i_ack_stall)))
        else $error("acknowledgement loaded over a pending one");

    a_first_byte_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ack_load |=> (o_ack_valid && o_ack_data.ack_byte[7]))
        else $error("first acknowledgement byte lacks the acknowledge bit");

    a_err_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ack_xfer && !o_ack_data.ack_last) |=>
            (o_ack_valid && o_ack_data.checksum_error == $past(o_ack_data.checksum_error)))
        else $error("error flag changed within an acknowledgement");

    a_end_of_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ack_xfer && o_ack_data.ack_last && !ack_load) |=> !o_ack_valid)
        else $error("output still valid after the last acknowledgement byte");

endmodule

`default_nettype wire
